@@ hw/rtl/ers_pkg.sv @@
// ----------------------------------------------------------------------------
// ers_pkg
// Types, constants and helpers shared by the elevator request scheduler.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int NUM_FLOORS = 64;
  localparam int DEPTH      = 16;

  localparam int FLOOR_W = 6;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  typedef enum logic [2:0] {
    STAT_ADDED = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_MOVED = 3'd3,
    STAT_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_GT,
    CMP_LT
  } cmp_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic [FLOOR_W-1:0] request_floor;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [FLOOR_W-1:0] served_floor;
    logic               going_up;
    logic [4:0]         pending_count;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [FLOOR_W-1:0] data;
  } mem_wr_t;

  // Clamp a requested floor to the top floor of the building.
  function automatic logic [FLOOR_W-1:0] sat_floor(input logic [FLOOR_W-1:0] f);
    logic [FLOOR_W-1:0] res;
    if (int'(f) > NUM_FLOORS - 1) begin
      res = FLOOR_W'(NUM_FLOORS - 1);
    end else begin
      res = f;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/ers_mem.sv @@
// ----------------------------------------------------------------------------
// ers_mem
// Pending floor list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ers_mem
  import ers_pkg::*;
(
  input  logic               clk,
  input  mem_wr_t            wr,
  input  logic               ren,
  input  logic [IDX_W-1:0]   raddr,
  output logic [FLOOR_W-1:0] rdata
);

  logic [FLOOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ers_cmp.sv @@
// ----------------------------------------------------------------------------
// ers_cmp
// Shared floor comparator used for the duplicate check and the stop search.
// ----------------------------------------------------------------------------
module ers_cmp
  import ers_pkg::*;
(
  input  cmp_mode_t          mode,
  input  logic [FLOOR_W-1:0] a,
  input  logic [FLOOR_W-1:0] b,
  output logic               hit
);

  always_comb begin
    unique case (mode)
      CMP_EQ:  hit = (a == b);
      CMP_GT:  hit = (a > b);
      CMP_LT:  hit = (a < b);
      default: hit = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/elevator_request_scheduler.sv @@
// ----------------------------------------------------------------------------
// elevator_request_scheduler
// Keeps an arrival-ordered list of floor requests and picks the next stop.
// ----------------------------------------------------------------------------
// One transaction at a time: the input stalls from acceptance until the result
// is loaded into the output register, which then holds it while the next
// transaction is accepted. A list memory with one write and one read port and
// one shared comparator walk the list one entry per cycle. An add scans the
// list for a duplicate and appends the floor if none is found; a full-list add
// or an empty serve goes straight to the result. A serve scans in the current
// direction and, if nothing hits, in the other one (the direction flips when
// the stop is found there), then shifts the later entries down at one per
// cycle. The result waits while the output register stays stalled with an
// older result. No clearing pass after reset: only the first pending_count
// entries are ever read.
module elevator_request_scheduler
  import ers_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [FLOOR_W-1:0] cur, cur_next;
  logic               up, up_next;
  logic               op_serve, op_serve_next;
  logic [FLOOR_W-1:0] floor, floor_next;
  logic               dir, dir_next;
  logic               second, second_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               rd_vld, rd_vld_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [FLOOR_W-1:0] head, head_next;
  status_t            stat, stat_next;
  logic               out_valid_next;
  rsp_t               out_data_next;

  mem_wr_t            wr;
  logic               ren;
  logic [IDX_W-1:0]   raddr;
  logic [FLOOR_W-1:0] rdata;

  cmp_mode_t          cmp_mode;
  logic [FLOOR_W-1:0] cmp_b;
  logic               hit;

  ers_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmp_mode = op_serve ? (dir ? CMP_GT : CMP_LT) : CMP_EQ;
  assign cmp_b    = op_serve ? cur : floor;

  ers_cmp u_cmp (
    .mode (cmp_mode),
    .a    (rdata),
    .b    (cmp_b),
    .hit  (hit)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur       <= '0;
      up        <= 1'b1;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cur       <= cur_next;
      up        <= up_next;
      rd_vld    <= rd_vld_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_serve <= op_serve_next;
    floor    <= floor_next;
    dir      <= dir_next;
    second   <= second_next;
    idx      <= idx_next;
    rd_idx   <= rd_idx_next;
    head     <= head_next;
    stat     <= stat_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    cur_next       = cur;
    up_next        = up;
    op_serve_next  = op_serve;
    floor_next     = floor;
    dir_next       = dir;
    second_next    = second;
    idx_next       = idx;
    rd_vld_next    = 1'b0;
    rd_idx_next    = rd_idx;
    head_next      = head;
    stat_next      = stat;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    wr             = '0;
    ren            = 1'b0;
    raddr          = idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_serve_next = in_data.req_type;
          floor_next    = sat_floor(in_data.request_floor);
          dir_next      = up;
          second_next   = 1'b0;
          idx_next      = '0;
          if (!in_data.req_type && (int'(count) >= DEPTH)) begin
            stat_next  = STAT_FULL;
            state_next = S_DONE;
          end else if (in_data.req_type && (count == '0)) begin
            stat_next  = STAT_EMPTY;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // keep the oldest entry for the fallback when neither direction hits
        if (rd_vld && (rd_idx == '0)) begin
          head_next = rdata;
        end
        if (rd_vld && hit) begin
          if (!op_serve) begin
            stat_next  = STAT_DUP;
            state_next = S_DONE;
          end else begin
            cur_next   = rdata;
            if (second) begin
              up_next = ~up;
            end
            idx_next   = CNT_W'(rd_idx) + CNT_W'(1);
            state_next = S_SHIFT;
          end
        end else if (!rd_vld && (idx == count)) begin
          if (!op_serve) begin
            wr.en      = 1'b1;
            wr.addr    = count[IDX_W-1:0];
            wr.data    = floor;
            count_next = count + CNT_W'(1);
            stat_next  = STAT_ADDED;
            state_next = S_DONE;
          end else if (!second) begin
            second_next = 1'b1;
            dir_next    = ~dir;
            idx_next    = '0;
          end else begin
            cur_next   = head;
            idx_next   = CNT_W'(1);
            state_next = S_SHIFT;
          end
        end else if (idx != count) begin
          ren         = 1'b1;
          rd_vld_next = 1'b1;
          rd_idx_next = idx[IDX_W-1:0];
          idx_next    = idx + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        // move each later entry down one place to close the gap
        if (rd_vld) begin
          wr.en   = 1'b1;
          wr.addr = rd_idx - IDX_W'(1);
          wr.data = rdata;
        end
        if (idx != count) begin
          ren         = 1'b1;
          rd_vld_next = 1'b1;
          rd_idx_next = idx[IDX_W-1:0];
          idx_next    = idx + CNT_W'(1);
        end else if (!rd_vld) begin
          count_next = count - CNT_W'(1);
          stat_next  = STAT_MOVED;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next              = 1'b1;
          out_data_next.status        = stat;
          out_data_next.served_floor  = cur;
          out_data_next.going_up      = up;
          out_data_next.pending_count = 5'(count);
          state_next                  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
